FILE: src/joint_pd_torque_with_velocity_filter_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the joint PD torque block
// Shared property forms used by the RTL modules. Each use expands to one
// labeled concurrent assertion clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef JOINT_PD_TORQUE_WITH_VELOCITY_FILTER_MACROS_SVH
`define JOINT_PD_TORQUE_WITH_VELOCITY_FILTER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define JPDT_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define JPDT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/jpdt_pkg.sv
// ----------------------------------------------------------------------------
// jpdt_pkg
// Types and fixed constants for the joint PD torque block: word formats,
// register indexes, sequencer states and shared-unit control codes.
// ----------------------------------------------------------------------------
package jpdt_pkg;

    localparam int JOINT_W     = 3;
    localparam int POS_W       = 16;
    localparam int PERR_W      = POS_W + 1;
    localparam int TORQUE_W    = 24;
    localparam int LEN_W       = 5;
    localparam int GAIN_W      = 16;
    localparam int CFG_W       = 64;
    localparam int GAINS_HI_W  = 48;
    localparam int CFG_IDX_W   = 3;

    // Gains are Q10.6, positions Q4.12, torques Q16.8: products carry ten
    // more fraction bits than the torque.
    localparam int ROUND_SHIFT = 10;

    // Shared multiplier operand widths and the accumulator width.
    localparam int MUL_A_W     = 36;
    localparam int MUL_B_W     = 18;
    localparam int PROD_W      = MUL_A_W + MUL_B_W;
    localparam int ACC_W       = 44;

    // Divider: dividend width and quotient bits retired per cycle.
    localparam int DIV_W          = 32;
    localparam int DIV_RADIX_BITS = 2;

    localparam logic [LEN_W-1:0] FILTER_LENGTH_RESET = 5'd5;
    localparam logic signed [TORQUE_W-1:0] TORQUE_MAX = 24'sh7FFFFF;
    localparam logic signed [TORQUE_W-1:0] TORQUE_MIN = 24'sh800000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FILTER_LENGTH = 3'd0,
        CFG_KP_LO         = 3'd1,
        CFG_KP_HI         = 3'd2,
        CFG_KD_LO         = 3'd3,
        CFG_KD_HI         = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic [JOINT_W-1:0]         joint_index;
        logic signed [POS_W-1:0]    joint_position;
        logic signed [POS_W-1:0]    joint_velocity;
        logic signed [POS_W-1:0]    desired_position;
        logic signed [POS_W-1:0]    desired_velocity;
        logic signed [TORQUE_W-1:0] coriolis_torque;
    } sample_t;

    typedef struct packed {
        logic [JOINT_W-1:0]         torque_joint;
        logic signed [TORQUE_W-1:0] torque_command;
        logic                       torque_saturated;
    } torque_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SUM,
        ST_SUM_TAIL,
        ST_MUL_KP,
        ST_MUL_KD,
        ST_ADD_KD,
        ST_MUL_L,
        ST_MUL_KDS,
        ST_ADD_KDS,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_OUT
    } state_t;

    typedef enum logic [2:0] {
        MUL_IDLE,
        MUL_PERR_KP,
        MUL_DVEL_KD,
        MUL_ACC_LEN,
        MUL_SUM_KD
    } mul_sel_t;

    typedef enum logic [2:0] {
        ACC_HOLD,
        ACC_KP_COR,
        ACC_ADD_PROD,
        ACC_LOAD_PROD,
        ACC_SUB_ROUND
    } acc_op_t;

    typedef struct packed {
        logic     idle;
        logic     rd_issue;
        mul_sel_t mul_sel;
        acc_op_t  acc_op;
        logic     div_start;
        logic     load_res;
        logic     out_load;
    } ctl_t;

endpackage

FILE: src/jpdt_div.sv
// ----------------------------------------------------------------------------
// jpdt_div
// Iterative unsigned restoring divider by a short divisor. Retires
// DIV_RADIX_BITS quotient bits per cycle; busy stays high until done.
// ----------------------------------------------------------------------------
`include "joint_pd_torque_with_velocity_filter_macros.svh"

module jpdt_div
    import jpdt_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DIV_W-1:0] dividend,
    input  logic [LEN_W-1:0] divisor,
    output logic             busy,
    output logic [DIV_W-1:0] quotient
);

    localparam int STEPS = DIV_W / DIV_RADIX_BITS;
    localparam int CNT_W = $clog2(STEPS + 1);

    logic             busy_reg, busy_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_W-1:0] quo_reg, quo_next;
    logic [LEN_W-1:0] rem_reg, rem_next;
    logic [LEN_W-1:0] den_reg, den_next;
    logic [LEN_W:0]   trial;

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        trial     = '0;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(STEPS);
            quo_next  = dividend;
            rem_next  = '0;
            den_next  = divisor;
        end
        else if (busy_reg)
        begin
            // The dividend shifts out at the top while quotient bits enter
            // at the bottom of the same register.
            for (int i = 0; i < DIV_RADIX_BITS; i++)
            begin
                trial    = {rem_next, quo_next[DIV_W-1]};
                quo_next = {quo_next[DIV_W-2:0], 1'b0};
                if (trial >= {1'b0, den_reg})
                begin
                    rem_next    = LEN_W'(trial - {1'b0, den_reg});
                    quo_next[0] = 1'b1;
                end
                else
                begin
                    rem_next = trial[LEN_W-1:0];
                end
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

    `JPDT_ASSERT_IMPLY(a_div_no_restart, start, !busy_reg, "divider restarted while busy")
    `JPDT_ASSERT_IMPLY(a_div_nonzero, start, divisor != '0, "divider started with zero divisor")
    `JPDT_ASSERT_IMPLY(a_div_rem_bound, busy_reg, rem_reg < den_reg, "remainder not below divisor")
    `JPDT_ASSERT_NEXT(a_div_finish, busy_reg && cnt_reg == CNT_W'(1), !busy_reg, "divider overran")

endmodule

FILE: src/joint_pd_torque_with_velocity_filter.sv
// ----------------------------------------------------------------------------
// joint_pd_torque_with_velocity_filter
// Per-joint PD torque with a moving-average filter on measured velocity.
// ----------------------------------------------------------------------------
// Takes one joint sample per word and returns one torque word for it. The
// velocity goes into that joint's ring of filter_length history entries, the
// ring is summed one entry per cycle from a history memory with one write
// port and one read port, and kp*(dpos-pos) + kd*(dvel-avg) + coriolis is
// formed exactly on one shared multiplier, then rounded to nearest (ties up)
// by an iterative divider that retires two quotient bits per cycle and
// saturated to 24 bits. A valid joint runs the history sweep, the multiply
// and add steps and the divide before the next sample is accepted; a joint
// index of JOINTS or more skips all of these and returns a zero torque. The
// sample channel stalls while an item is in work; the finished word waits in
// an output register. Reset clears the history at once through per-entry
// valid bits, so no clearing pass is needed.
`include "joint_pd_torque_with_velocity_filter_macros.svh"

module joint_pd_torque_with_velocity_filter
    import jpdt_pkg::*;
#(
    parameter int JOINTS     = 7,
    parameter int MAX_FILTER = 16
)(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 sample_valid,
    output logic                 sample_stall,
    input  sample_t              sample,
    output logic                 torque_valid,
    input  logic                 torque_stall,
    output torque_t              torque
);

    localparam int DEPTH  = JOINTS * MAX_FILTER;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SLOT_W = (MAX_FILTER > 1) ? $clog2(MAX_FILTER) : 1;
    localparam int SUM_W  = POS_W + LEN_W;
    localparam int QS_W   = DIV_W + 1;

    function automatic logic [GAIN_W-1:0] gain_of(
        input logic [CFG_W-1:0]      lo,
        input logic [GAINS_HI_W-1:0] hi,
        input logic [JOINT_W-1:0]    j
    );
        logic [GAIN_W-1:0] g;
        g = '0;
        case (j)
            3'd0:    g = lo[0*GAIN_W +: GAIN_W];
            3'd1:    g = lo[1*GAIN_W +: GAIN_W];
            3'd2:    g = lo[2*GAIN_W +: GAIN_W];
            3'd3:    g = lo[3*GAIN_W +: GAIN_W];
            3'd4:    g = hi[0*GAIN_W +: GAIN_W];
            3'd5:    g = hi[1*GAIN_W +: GAIN_W];
            3'd6:    g = hi[2*GAIN_W +: GAIN_W];
            default: g = '0;
        endcase
        return g;
    endfunction

    // Configuration registers.
    logic [LEN_W-1:0]      filter_length_reg;
    logic [CFG_W-1:0]      kp_lo_reg, kd_lo_reg;
    logic [GAINS_HI_W-1:0] kp_hi_reg, kd_hi_reg;

    // Sequencer and control state.
    state_t            state_reg, state_next;
    ctl_t              ctl;
    logic [SLOT_W-1:0] write_slot_reg;
    logic              rd_pend_reg;
    logic              torque_valid_reg;
    torque_t           torque_reg;

    // Item and datapath registers.
    logic [JOINT_W-1:0]         joint_reg;
    logic signed [PERR_W-1:0]   perr_reg;
    logic signed [POS_W-1:0]    dvel_reg;
    logic signed [TORQUE_W-1:0] cor_reg;
    logic [GAIN_W-1:0]          kp_reg, kd_reg;
    logic [LEN_W-1:0]           len_reg;
    logic [ADDR_W-1:0]          rd_addr_reg;
    logic [LEN_W-1:0]           rd_cnt_reg;
    logic signed [POS_W-1:0]    rd_data_reg;
    logic                       rd_ok_reg;
    logic signed [SUM_W-1:0]    sum_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [ACC_W-1:0]    acc_reg;
    logic                       neg_reg;
    logic signed [TORQUE_W-1:0] res_torque_reg;
    logic                       res_sat_reg;

    // History memory and its valid bits.
    logic signed [POS_W-1:0] hist_mem [DEPTH];
    logic [DEPTH-1:0]        hist_valid_reg;

    // Combinational signals.
    logic                       accept;
    logic                       joint_ok;
    logic [LEN_W-1:0]           eff_len;
    logic [SLOT_W-1:0]          slot_cur;
    logic [SLOT_W-1:0]          slot_adv;
    logic [ADDR_W-1:0]          wr_addr;
    logic                       hist_we;
    logic                       rd_last;
    logic signed [MUL_A_W-1:0]  mul_a;
    logic signed [MUL_B_W-1:0]  mul_b;
    logic signed [PROD_W-1:0]   prod_next;
    logic signed [ACC_W-1:0]    round_m;
    logic signed [ACC_W-1:0]    div_arg;
    logic [DIV_W-1:0]           div_dividend;
    logic [DIV_W-1:0]           div_quot;
    logic                       div_busy;
    logic signed [QS_W-1:0]     quot_s;
    logic signed [TORQUE_W-1:0] sat_torque;
    logic                       sat_flag;

    assign accept   = sample_valid && !sample_stall;
    assign joint_ok = int'(sample.joint_index) < JOINTS;
    assign hist_we  = accept && joint_ok;
    assign rd_last  = rd_cnt_reg == LEN_W'(len_reg - LEN_W'(1));

    // A zero length acts as one; lengths above the ring depth are clipped.
    always_comb
    begin
        eff_len = filter_length_reg;
        if (filter_length_reg == '0)
        begin
            eff_len = LEN_W'(1);
        end
        else if (int'(filter_length_reg) > MAX_FILTER)
        begin
            eff_len = LEN_W'(MAX_FILTER);
        end
    end

    // After the length was lowered, a slot past the end wraps to zero.
    always_comb
    begin
        slot_cur = write_slot_reg;
        if (int'(write_slot_reg) >= int'(eff_len))
        begin
            slot_cur = '0;
        end
        slot_adv = SLOT_W'(int'(slot_cur) + 1);
        if (int'(slot_cur) + 1 >= int'(eff_len))
        begin
            slot_adv = '0;
        end
        wr_addr = ADDR_W'(int'(slot_cur) * JOINTS + int'(sample.joint_index));
    end

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = joint_ok ? ST_SUM : ST_OUT;
                end
            end
            ST_SUM:
            begin
                if (rd_last)
                begin
                    state_next = ST_SUM_TAIL;
                end
            end
            ST_SUM_TAIL:  state_next = ST_MUL_KP;
            ST_MUL_KP:    state_next = ST_MUL_KD;
            ST_MUL_KD:    state_next = ST_ADD_KD;
            ST_ADD_KD:    state_next = ST_MUL_L;
            ST_MUL_L:     state_next = ST_MUL_KDS;
            ST_MUL_KDS:   state_next = ST_ADD_KDS;
            ST_ADD_KDS:   state_next = ST_DIV_START;
            ST_DIV_START: state_next = ST_DIV_WAIT;
            ST_DIV_WAIT:
            begin
                if (!div_busy)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!torque_valid_reg || !torque_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Control decode per state.
    always_comb
    begin
        ctl = '0;
        unique case (state_reg)
            ST_IDLE:      ctl.idle = 1'b1;
            ST_SUM:       ctl.rd_issue = 1'b1;
            ST_SUM_TAIL:  ctl.mul_sel = MUL_IDLE;
            ST_MUL_KP:    ctl.mul_sel = MUL_PERR_KP;
            ST_MUL_KD:
            begin
                ctl.mul_sel = MUL_DVEL_KD;
                ctl.acc_op  = ACC_KP_COR;
            end
            ST_ADD_KD:    ctl.acc_op = ACC_ADD_PROD;
            ST_MUL_L:     ctl.mul_sel = MUL_ACC_LEN;
            ST_MUL_KDS:
            begin
                ctl.mul_sel = MUL_SUM_KD;
                ctl.acc_op  = ACC_LOAD_PROD;
            end
            ST_ADD_KDS:   ctl.acc_op = ACC_SUB_ROUND;
            ST_DIV_START: ctl.div_start = 1'b1;
            ST_DIV_WAIT:  ctl.load_res = !div_busy;
            ST_OUT:       ctl.out_load = !torque_valid_reg || !torque_stall;
            default:      ctl.idle = 1'b0;
        endcase
    end

    assign sample_stall = !ctl.idle;

    // Shared multiplier operand selection.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (ctl.mul_sel)
            MUL_PERR_KP:
            begin
                mul_a = MUL_A_W'(perr_reg);
                mul_b = MUL_B_W'(kp_reg);
            end
            MUL_DVEL_KD:
            begin
                mul_a = MUL_A_W'(dvel_reg);
                mul_b = MUL_B_W'(kd_reg);
            end
            MUL_ACC_LEN:
            begin
                mul_a = MUL_A_W'(acc_reg);
                mul_b = MUL_B_W'(len_reg);
            end
            MUL_SUM_KD:
            begin
                mul_a = MUL_A_W'(sum_reg);
                mul_b = MUL_B_W'(kd_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod_next = mul_a * mul_b;
    end

    // Floor division by L of a negative value is done as a truncating
    // division of the biased magnitude, then negated.
    always_comb
    begin
        round_m = acc_reg >>> ROUND_SHIFT;
        div_arg = round_m;
        if (round_m[ACC_W-1])
        begin
            div_arg = -round_m + ACC_W'(signed'({1'b0, len_reg})) - ACC_W'(1);
        end
        div_dividend = div_arg[DIV_W-1:0];
    end

    always_comb
    begin
        quot_s = QS_W'(signed'({1'b0, div_quot}));
        if (neg_reg)
        begin
            quot_s = -quot_s;
        end
        sat_torque = quot_s[TORQUE_W-1:0];
        sat_flag   = 1'b0;
        if (quot_s > QS_W'(TORQUE_MAX))
        begin
            sat_torque = TORQUE_MAX;
            sat_flag   = 1'b1;
        end
        else if (quot_s < QS_W'(TORQUE_MIN))
        begin
            sat_torque = TORQUE_MIN;
            sat_flag   = 1'b1;
        end
    end

    jpdt_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (ctl.div_start),
        .dividend (div_dividend),
        .divisor  (len_reg),
        .busy     (div_busy),
        .quotient (div_quot)
    );

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filter_length_reg <= FILTER_LENGTH_RESET;
            kp_lo_reg         <= '0;
            kp_hi_reg         <= '0;
            kd_lo_reg         <= '0;
            kd_hi_reg         <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_FILTER_LENGTH: filter_length_reg <= cfg_data[LEN_W-1:0];
                CFG_KP_LO:         kp_lo_reg <= cfg_data;
                CFG_KP_HI:         kp_hi_reg <= cfg_data[GAINS_HI_W-1:0];
                CFG_KD_LO:         kd_lo_reg <= cfg_data;
                CFG_KD_HI:         kd_hi_reg <= cfg_data[GAINS_HI_W-1:0];
                default:           kp_lo_reg <= kp_lo_reg;
            endcase
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            write_slot_reg   <= '0;
            rd_pend_reg      <= 1'b0;
            torque_valid_reg <= 1'b0;
            hist_valid_reg   <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            rd_pend_reg <= ctl.rd_issue;
            if (hist_we)
            begin
                hist_valid_reg[wr_addr] <= 1'b1;
                // Only the last joint moves the ring on.
                if (int'(sample.joint_index) == JOINTS - 1)
                begin
                    write_slot_reg <= slot_adv;
                end
                else
                begin
                    write_slot_reg <= slot_cur;
                end
            end
            if (ctl.out_load)
            begin
                torque_valid_reg <= 1'b1;
            end
            else if (!torque_stall)
            begin
                torque_valid_reg <= 1'b0;
            end
        end
    end

    // History memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (hist_we)
        begin
            hist_mem[wr_addr] <= sample.joint_velocity;
        end
        rd_data_reg <= hist_mem[rd_addr_reg];
        rd_ok_reg   <= hist_valid_reg[rd_addr_reg];
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        if (accept)
        begin
            joint_reg      <= sample.joint_index;
            perr_reg       <= PERR_W'(sample.desired_position)
                              - PERR_W'(sample.joint_position);
            dvel_reg       <= sample.desired_velocity;
            cor_reg        <= sample.coriolis_torque;
            kp_reg         <= gain_of(kp_lo_reg, kp_hi_reg, sample.joint_index);
            kd_reg         <= gain_of(kd_lo_reg, kd_hi_reg, sample.joint_index);
            len_reg        <= eff_len;
            rd_addr_reg    <= ADDR_W'(sample.joint_index);
            rd_cnt_reg     <= '0;
            sum_reg        <= '0;
            res_torque_reg <= '0;
            res_sat_reg    <= 1'b0;
        end
        else
        begin
            if (ctl.rd_issue)
            begin
                rd_cnt_reg <= rd_cnt_reg + LEN_W'(1);
                if (!rd_last)
                begin
                    rd_addr_reg <= ADDR_W'(int'(rd_addr_reg) + JOINTS);
                end
            end
            // Entries never written since reset count as zero.
            if (rd_pend_reg && rd_ok_reg)
            begin
                sum_reg <= sum_reg + SUM_W'(rd_data_reg);
            end
            if (ctl.load_res)
            begin
                res_torque_reg <= sat_torque;
                res_sat_reg    <= sat_flag;
            end
        end

        case (ctl.acc_op)
            ACC_KP_COR:    acc_reg <= ACC_W'(prod_reg) + (ACC_W'(cor_reg) <<< ROUND_SHIFT);
            ACC_ADD_PROD:  acc_reg <= acc_reg + ACC_W'(prod_reg);
            ACC_LOAD_PROD: acc_reg <= ACC_W'(prod_reg);
            ACC_SUB_ROUND: acc_reg <= acc_reg - ACC_W'(prod_reg)
                                      + (ACC_W'(signed'({1'b0, len_reg})) <<< (ROUND_SHIFT - 1));
            default:       acc_reg <= acc_reg;
        endcase

        if (ctl.div_start)
        begin
            neg_reg <= acc_reg[ACC_W-1];
        end

        if (ctl.out_load)
        begin
            torque_reg.torque_joint     <= joint_reg;
            torque_reg.torque_command   <= res_torque_reg;
            torque_reg.torque_saturated <= res_sat_reg;
        end
    end

    assign torque_valid = torque_valid_reg;
    assign torque       = torque_reg;

    `JPDT_ASSERT_IMPLY(a_div_in_wait, div_busy, state_reg == ST_DIV_WAIT, "divider busy outside wait")
    `JPDT_ASSERT_IMPLY(a_sum_bound, state_reg == ST_SUM, rd_cnt_reg < len_reg, "history sweep overran")
    `JPDT_ASSERT_IMPLY(a_sat_value, torque_valid_reg && torque_reg.torque_saturated, torque_reg.torque_command == TORQUE_MAX || torque_reg.torque_command == TORQUE_MIN, "saturated torque not at a limit")
    `JPDT_ASSERT_NEXT(a_out_load, ctl.out_load, torque_valid_reg && state_reg == ST_IDLE, "result word not presented")

endmodule
